@@ rtl/bipbuf_pkg.sv @@
// Shared types and request codes for the bip buffer index manager.
// No dependencies.
package bipbuf_pkg;

  localparam int unsigned FieldW   = 13;  // width of amount and size fields
  localparam int unsigned OffsetW  = 12;
  localparam int unsigned SpaceW   = 12;
  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned ResetSize = 4096;

  // Request codes; anything above REQ_STATUS behaves as a status query
  localparam logic [ReqTypeW-1:0] REQ_WR_ACQ = 3'd0;
  localparam logic [ReqTypeW-1:0] REQ_WR_REL = 3'd1;
  localparam logic [ReqTypeW-1:0] REQ_RD_ACQ = 3'd2;
  localparam logic [ReqTypeW-1:0] REQ_RD_REL = 3'd3;
  localparam logic [ReqTypeW-1:0] REQ_STATUS = 3'd4;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [FieldW-1:0]   amount;
    logic                want_max;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [OffsetW-1:0] region_offset;
    logic [FieldW-1:0]  region_length;
    logic               is_empty;
    logic [SpaceW-1:0]  free_space;
    logic [SpaceW-1:0]  used_space;
  } result_t;

endpackage

@@ rtl/bipbuf_calc.sv @@
// Request evaluation: next indices, flags and result for one registered request.
// Depends on bipbuf_pkg.
module bipbuf_calc #(
  parameter int unsigned MAX_SIZE = 4096
) (
  input  bipbuf_pkg::req_t                      req_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]         size_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]         wr_pos_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]         rd_pos_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]         inv_pos_i,
  input  logic                                  wr_wrap_i,
  input  logic                                  rd_wrap_i,
  output logic [$clog2(MAX_SIZE+1)-1:0]         wr_pos_o,
  output logic [$clog2(MAX_SIZE+1)-1:0]         rd_pos_o,
  output logic [$clog2(MAX_SIZE+1)-1:0]         inv_pos_o,
  output logic                                  wr_wrap_o,
  output logic                                  rd_wrap_o,
  output bipbuf_pkg::result_t                   res_o
);
  import bipbuf_pkg::*;

  localparam int unsigned PW = $clog2(MAX_SIZE + 1);
  localparam int unsigned AW = ((PW > FieldW) ? PW : FieldW) + 1;

  logic [AW-1:0] sz, w, r, inv, amt;
  logic [AW-1:0] avail, linear, lin, head, needed;
  logic [AW-1:0] base, adv, inv_n, w_n, r_n;
  logic [AW-1:0] off, len, fr, used;
  logic          grant, wwrap_n, rwrap_n;

  // ring free space, one slot kept spare
  function automatic logic [AW-1:0] free_bytes(input logic [AW-1:0] s,
                                               input logic [AW-1:0] wp,
                                               input logic [AW-1:0] rp);
    if (rp > wp) begin
      return rp - wp - AW'(1);
    end
    return s - (wp - rp) - AW'(1);
  endfunction

  assign sz  = AW'(size_i);
  assign w   = AW'(wr_pos_i);
  assign r   = AW'(rd_pos_i);
  assign inv = AW'(inv_pos_i);
  assign amt = AW'(req_i.amount);

  assign avail  = free_bytes(sz, w, r);
  assign linear = sz - w;
  assign lin    = (avail < linear) ? avail : linear;
  assign head   = avail - lin;

  always_comb begin
    w_n     = w;
    r_n     = r;
    inv_n   = inv;
    wwrap_n = wr_wrap_i;
    rwrap_n = rd_wrap_i;
    grant   = 1'b0;
    off     = '0;
    len     = '0;
    needed  = amt;
    base    = '0;
    adv     = '0;
    case (req_i.req_type)
      REQ_WR_ACQ: begin
        if (req_i.want_max) begin
          needed = (lin < head) ? head : lin;
        end
        if (needed != '0) begin
          if (needed <= lin) begin
            grant = 1'b1;
            off   = w;
          end else if (needed <= head) begin
            wwrap_n = 1'b1;
            grant   = 1'b1;
          end
        end
        len = needed;
      end
      REQ_WR_REL: begin
        // a pending wrap moves the data end marker to the old write index
        if (wr_wrap_i) begin
          wwrap_n = 1'b0;
          inv_n   = w;
          base    = '0;
        end else begin
          base = w;
        end
        adv = base + amt;
        if (adv > sz) begin
          adv = sz;
        end
        if (adv > inv_n) begin
          inv_n = adv;
        end
        w_n = (adv == sz) ? '0 : adv;
      end
      REQ_RD_ACQ: begin
        if (r == w) begin
          len = '0;
        end else if (r < w) begin
          grant = 1'b1;
          off   = r;
          len   = w - r;
        end else if (r == inv) begin
          rwrap_n = 1'b1;
          grant   = 1'b1;
          len     = w;
        end else begin
          grant = 1'b1;
          off   = r;
          len   = (inv > r) ? inv - r : '0;
        end
      end
      REQ_RD_REL: begin
        if (rd_wrap_i) begin
          rwrap_n = 1'b0;
          base    = '0;
        end else begin
          base = r;
        end
        adv = base + amt;
        if (adv > sz) begin
          adv = sz;
        end
        r_n = (adv == sz) ? '0 : adv;
      end
      default: begin
      end
    endcase
  end

  assign fr   = free_bytes(sz, w_n, r_n);
  assign used = sz - fr - AW'(1);

  assign wr_pos_o  = w_n[PW-1:0];
  assign rd_pos_o  = r_n[PW-1:0];
  assign inv_pos_o = inv_n[PW-1:0];
  assign wr_wrap_o = wwrap_n;
  assign rd_wrap_o = rwrap_n;

  assign res_o.granted       = grant;
  assign res_o.region_offset = off[OffsetW-1:0];
  assign res_o.region_length = len[FieldW-1:0];
  assign res_o.is_empty      = (r_n == w_n);
  assign res_o.free_space    = fr[SpaceW-1:0];
  assign res_o.used_space    = used[SpaceW-1:0];

endmodule

@@ rtl/bipbuf_state.sv @@
// Index, flag and size registers with the size write and its clamp.
// Depends on bipbuf_pkg.
module bipbuf_state #(
  parameter int unsigned MAX_SIZE = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bipbuf_pkg::FieldW-1:0]         cfg_wdata_i,
  input  logic                                  upd_en_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]         wr_pos_d_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]         rd_pos_d_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]         inv_pos_d_i,
  input  logic                                  wr_wrap_d_i,
  input  logic                                  rd_wrap_d_i,
  output logic [$clog2(MAX_SIZE+1)-1:0]         size_o,
  output logic [$clog2(MAX_SIZE+1)-1:0]         wr_pos_o,
  output logic [$clog2(MAX_SIZE+1)-1:0]         rd_pos_o,
  output logic [$clog2(MAX_SIZE+1)-1:0]         inv_pos_o,
  output logic                                  wr_wrap_o,
  output logic                                  rd_wrap_o
);
  import bipbuf_pkg::*;

  localparam int unsigned PW = $clog2(MAX_SIZE + 1);
  localparam int unsigned AW = ((PW > FieldW) ? PW : FieldW) + 1;
  localparam int unsigned RstSize = (ResetSize > MAX_SIZE) ? MAX_SIZE : ResetSize;

  logic [PW-1:0] size_q, size_d;
  logic [PW-1:0] wr_pos_q, rd_pos_q, inv_pos_q;
  logic          wr_wrap_q, rd_wrap_q;
  logic [AW-1:0] wdata_ext;

  assign wdata_ext = AW'(cfg_wdata_i);

  always_comb begin
    if (wdata_ext < AW'(2)) begin
      size_d = PW'(2);
    end else if (wdata_ext > AW'(MAX_SIZE)) begin
      size_d = PW'(MAX_SIZE);
    end else begin
      size_d = wdata_ext[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= PW'(RstSize);
      wr_pos_q  <= '0;
      rd_pos_q  <= '0;
      inv_pos_q <= '0;
      wr_wrap_q <= 1'b0;
      rd_wrap_q <= 1'b0;
    end else if (cfg_we_i) begin
      // a new size restarts the buffer
      size_q    <= size_d;
      wr_pos_q  <= '0;
      rd_pos_q  <= '0;
      inv_pos_q <= '0;
      wr_wrap_q <= 1'b0;
      rd_wrap_q <= 1'b0;
    end else if (upd_en_i) begin
      wr_pos_q  <= wr_pos_d_i;
      rd_pos_q  <= rd_pos_d_i;
      inv_pos_q <= inv_pos_d_i;
      wr_wrap_q <= wr_wrap_d_i;
      rd_wrap_q <= rd_wrap_d_i;
    end
  end

  assign size_o    = size_q;
  assign wr_pos_o  = wr_pos_q;
  assign rd_pos_o  = rd_pos_q;
  assign inv_pos_o = inv_pos_q;
  assign wr_wrap_o = wr_wrap_q;
  assign rd_wrap_o = rd_wrap_q;

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q >= PW'(2)) && (AW'(size_q) <= AW'(MAX_SIZE)))
    else $error("size out of range");

  a_wr_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_pos_q < size_q) && (rd_pos_q < size_q))
    else $error("write or read index not wrapped");

  a_inv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inv_pos_q <= size_q)
    else $error("invalidate index beyond size");

endmodule

@@ rtl/bip_buffer_index_manager.sv @@
// Top level of the bip buffer index manager: request register, evaluation,
// index state and result register.
// Depends on bipbuf_pkg, bipbuf_calc and bipbuf_state.
// Pipeline: the request register, then evaluation into the result register;
//   the result strobe rises with the result register, and the result transfers
//   while the strobe is high.
// Throughput: one request per cycle; busy stays low, as state updates in the
//   same cycle a request is evaluated. The receiver cannot stall results.
// Reset: indices and wrap flags clear, size becomes 4096 (MAX_SIZE if less).
module bip_buffer_index_manager #(
  parameter int unsigned MAX_SIZE = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bipbuf_pkg::FieldW-1:0]    cfg_wdata_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [bipbuf_pkg::ReqTypeW-1:0]  req_type_i,
  input  logic [bipbuf_pkg::FieldW-1:0]    amount_i,
  input  logic                             want_max_i,
  output logic                             result_valid_o,
  output logic                             granted_o,
  output logic [bipbuf_pkg::OffsetW-1:0]   region_offset_o,
  output logic [bipbuf_pkg::FieldW-1:0]    region_length_o,
  output logic                             is_empty_o,
  output logic [bipbuf_pkg::SpaceW-1:0]    free_space_o,
  output logic [bipbuf_pkg::SpaceW-1:0]    used_space_o
);
  import bipbuf_pkg::*;

  localparam int unsigned PW = $clog2(MAX_SIZE + 1);

  req_t          req_q;
  logic          req_vld_q;
  result_t       res_d, res_q;
  logic          res_vld_q;
  logic          accept;

  logic [PW-1:0] size, wr_pos, rd_pos, inv_pos;
  logic [PW-1:0] wr_pos_d, rd_pos_d, inv_pos_d;
  logic          wr_wrap, rd_wrap, wr_wrap_d, rd_wrap_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      req_vld_q <= accept;
      res_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.req_type <= req_type_i;
      req_q.amount   <= amount_i;
      req_q.want_max <= want_max_i;
    end
    if (req_vld_q) begin
      res_q <= res_d;
    end
  end

  bipbuf_calc #(
    .MAX_SIZE (MAX_SIZE)
  ) u_calc (
    .req_i     (req_q),
    .size_i    (size),
    .wr_pos_i  (wr_pos),
    .rd_pos_i  (rd_pos),
    .inv_pos_i (inv_pos),
    .wr_wrap_i (wr_wrap),
    .rd_wrap_i (rd_wrap),
    .wr_pos_o  (wr_pos_d),
    .rd_pos_o  (rd_pos_d),
    .inv_pos_o (inv_pos_d),
    .wr_wrap_o (wr_wrap_d),
    .rd_wrap_o (rd_wrap_d),
    .res_o     (res_d)
  );

  bipbuf_state #(
    .MAX_SIZE (MAX_SIZE)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_en_i    (req_vld_q),
    .wr_pos_d_i  (wr_pos_d),
    .rd_pos_d_i  (rd_pos_d),
    .inv_pos_d_i (inv_pos_d),
    .wr_wrap_d_i (wr_wrap_d),
    .rd_wrap_d_i (rd_wrap_d),
    .size_o      (size),
    .wr_pos_o    (wr_pos),
    .rd_pos_o    (rd_pos),
    .inv_pos_o   (inv_pos),
    .wr_wrap_o   (wr_wrap),
    .rd_wrap_o   (rd_wrap)
  );

  assign result_valid_o  = res_vld_q;
  assign granted_o       = res_q.granted;
  assign region_offset_o = res_q.region_offset;
  assign region_length_o = res_q.region_length;
  assign is_empty_o      = res_q.is_empty;
  assign free_space_o    = res_q.free_space;
  assign used_space_o    = res_q.used_space;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 result_valid_o)
    else $error("result transfer missing two cycles after accept");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 2))
    else $error("result transfer without a request");

  a_ungranted_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !granted_o) |-> (region_offset_o == '0))
    else $error("offset set on a refused request");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the bip buffer index manager: a directed table, then
// random producer/consumer traffic over several store sizes, checked by typed rows or a predictor.
// Depends on bipbuf_pkg and bip_buffer_index_manager.
module testbench;
  import bipbuf_pkg::*;

  localparam int unsigned MaxSize = 4096;
  localparam int unsigned PhaseItems = 123;
  localparam int unsigned DrainLimit = 64;

  // request codes past REQ_STATUS, all treated as a status query
  localparam logic [ReqTypeW-1:0] REQ_SPARE5 = 3'd5;
  localparam logic [ReqTypeW-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [ReqTypeW-1:0] REQ_SPARE7 = 3'd7;

  typedef struct packed {
    logic [ReqTypeW-1:0] kind;
    logic [FieldW-1:0]   amt;
    logic                mx;
    logic                typed;  // expectation typed into the row
    result_t             res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [FieldW-1:0]    cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic [ReqTypeW-1:0]  req_type_i;
  logic [FieldW-1:0]    amount_i;
  logic                 want_max_i;
  logic                 result_valid_o;
  logic                 granted_o;
  logic [OffsetW-1:0]   region_offset_o;
  logic [FieldW-1:0]    region_length_o;
  logic                 is_empty_o;
  logic [SpaceW-1:0]    free_space_o;
  logic [SpaceW-1:0]    used_space_o;

  // predictor copy of the indices
  int unsigned sz, wpos, rpos, ipos;
  bit          wwrap, rwrap;

  result_t     grant_queue [$];
  int unsigned mismatches = 0;
  int unsigned idle_pct;
  dir_row_t    dir_tbl [20];

  bip_buffer_index_manager #(.MAX_SIZE(MaxSize)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .amount_i        (amount_i),
    .want_max_i      (want_max_i),
    .result_valid_o  (result_valid_o),
    .granted_o       (granted_o),
    .region_offset_o (region_offset_o),
    .region_length_o (region_length_o),
    .is_empty_o      (is_empty_o),
    .free_space_o    (free_space_o),
    .used_space_o    (used_space_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned ring_free();
    if (rpos > wpos) return rpos - wpos - 1;
    return sz - (wpos - rpos) - 1;
  endfunction

  function automatic void clear_indices();
    wpos = 0;
    rpos = 0;
    ipos = 0;
    wwrap = 1'b0;
    rwrap = 1'b0;
  endfunction

  function automatic void apply_size(logic [FieldW-1:0] v);
    int unsigned s;
    s = v;
    if (s < 2) s = 2;
    if (s > MaxSize) s = MaxSize;
    sz = s;
    clear_indices();
  endfunction

  // Works out the reply to one request and moves the predictor indices on.
  function automatic result_t predict_grant(logic [ReqTypeW-1:0] kind,
                                            logic [FieldW-1:0] amt, logic mx);
    result_t     r;
    int unsigned avail, linear, lin_avail, head, needed, w, inv, rd, fr;
    r = '0;
    case (kind)
      REQ_WR_ACQ: begin
        avail = ring_free();
        linear = sz - wpos;
        lin_avail = (avail < linear) ? avail : linear;
        head = avail - lin_avail;
        needed = amt;
        if (mx) needed = (lin_avail < head) ? head : lin_avail;
        if (needed > 0) begin
          if (needed <= lin_avail) begin
            r.granted = 1'b1;
            r.region_offset = OffsetW'(wpos);
          end else if (needed <= head) begin
            wwrap = 1'b1;
            r.granted = 1'b1;
          end
        end
        r.region_length = FieldW'(needed);
      end
      REQ_WR_REL: begin
        w = wpos;
        if (wwrap) begin
          wwrap = 1'b0;
          inv = w;
          w = 0;
        end else begin
          inv = ipos;
        end
        w = (w + amt > sz) ? sz : w + amt;
        if (w > inv) inv = w;
        if (w == sz) w = 0;
        ipos = inv;
        wpos = w;
      end
      REQ_RD_ACQ: begin
        if (rpos == wpos) begin
          r.region_length = '0;
        end else if (rpos < wpos) begin
          r.granted = 1'b1;
          r.region_offset = OffsetW'(rpos);
          r.region_length = FieldW'(wpos - rpos);
        end else if (rpos == ipos) begin
          rwrap = 1'b1;
          r.granted = 1'b1;
          r.region_length = FieldW'(wpos);
        end else begin
          // read index ahead of the write index, not at the invalidate mark: granted, up to the mark
          r.granted = 1'b1;
          r.region_offset = OffsetW'(rpos);
          r.region_length = (ipos > rpos) ? FieldW'(ipos - rpos) : '0;
        end
      end
      REQ_RD_REL: begin
        rd = rwrap ? 0 : rpos;
        rwrap = 1'b0;
        rd = (rd + amt > sz) ? sz : rd + amt;
        if (rd == sz) rd = 0;
        rpos = rd;
      end
      default: ;
    endcase
    fr = ring_free();
    r.is_empty = (rpos == wpos);
    r.free_space = SpaceW'(fr);
    r.used_space = SpaceW'(sz - fr - 1);
    return r;
  endfunction

  task automatic log_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (grant_queue.size() == 0) begin
        log_mismatch("unexpected result, pending", 0, 0);
      end else begin
        want = grant_queue.pop_front();
        if (granted_o != want.granted)
          log_mismatch("granted", granted_o, want.granted);
        if (region_offset_o != want.region_offset)
          log_mismatch("region_offset", region_offset_o, want.region_offset);
        if (region_length_o != want.region_length)
          log_mismatch("region_length", region_length_o, want.region_length);
        if (is_empty_o != want.is_empty)
          log_mismatch("is_empty", is_empty_o, want.is_empty);
        if (free_space_o != want.free_space)
          log_mismatch("free_space", free_space_o, want.free_space);
        if (used_space_o != want.used_space)
          log_mismatch("used_space", used_space_o, want.used_space);
      end
    end
  end

  // Called just after the clock rises; returns once the request is accepted, start still high.
  task automatic issue(input logic [ReqTypeW-1:0] kind, input logic [FieldW-1:0] amt,
                       input logic mx, input logic typed, input result_t typed_res,
                       output result_t pred);
    start <= 1'b1;
    req_type_i <= kind;
    amount_i <= amt;
    want_max_i <= mx;
    do @(posedge clk_i); while (busy);
    pred = predict_grant(kind, amt, mx);
    grant_queue.push_back(typed ? typed_res : pred);
  endtask

  task automatic hold(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
      hold($urandom_range(1, 18));
  endtask

  // Stop sending and wait for every pending reply; leftovers count as failures.
  task automatic drain();
    int unsigned n;
    hold(1);
    n = 0;
    while (grant_queue.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    while (grant_queue.size() != 0) begin
      log_mismatch("reply never arrived, pending", grant_queue.size(), 0);
      void'(grant_queue.pop_front());
    end
  endtask

  task automatic load_size(input logic [FieldW-1:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_size(v);
  endtask

  initial begin : stimulus
    logic [FieldW-1:0]   sizes [11];
    logic [ReqTypeW-1:0] kind;
    logic [FieldW-1:0]   amt;
    logic                mx;
    result_t             got;
    bit                  wr_open, rd_open;
    int unsigned         wr_len, rd_len;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    start <= 1'b0;
    req_type_i <= REQ_STATUS;
    amount_i <= '0;
    want_max_i <= 1'b0;

    dir_tbl = '{
      '{REQ_STATUS, 13'd0,    1'b0, 1'b1, '{1'b0, 12'd0, 13'd0,    1'b1, 12'd4095, 12'd0}},
      // zero-byte acquire is refused
      '{REQ_WR_ACQ, 13'd0,    1'b0, 1'b1, '{1'b0, 12'd0, 13'd0,    1'b1, 12'd4095, 12'd0}},
      '{REQ_RD_ACQ, 13'd0,    1'b1, 1'b1, '{1'b0, 12'd0, 13'd0,    1'b1, 12'd4095, 12'd0}},
      '{REQ_WR_ACQ, 13'd4096, 1'b0, 1'b1, '{1'b0, 12'd0, 13'd4096, 1'b1, 12'd4095, 12'd0}},
      '{REQ_WR_ACQ, 13'd0,    1'b1, 1'b1, '{1'b1, 12'd0, 13'd4095, 1'b1, 12'd4095, 12'd0}},
      '{REQ_WR_REL, 13'd3000, 1'b0, 1'b0, '0},
      '{REQ_RD_ACQ, 13'd0,    1'b0, 1'b0, '0},
      '{REQ_RD_REL, 13'd3000, 1'b0, 1'b0, '0},
      // does not fit at the end, so wraps to the start
      '{REQ_WR_ACQ, 13'd2000, 1'b0, 1'b0, '0},
      '{REQ_WR_REL, 13'd2000, 1'b0, 1'b0, '0},
      '{REQ_RD_REL, 13'd50,   1'b0, 1'b0, '0},
      // read index now beyond the invalidate mark
      '{REQ_RD_ACQ, 13'd0,    1'b0, 1'b0, '0},
      '{REQ_RD_REL, 13'd8191, 1'b0, 1'b0, '0},
      '{REQ_SPARE5, 13'd8191, 1'b1, 1'b0, '0},
      '{REQ_SPARE6, 13'd0,    1'b0, 1'b0, '0},
      '{REQ_SPARE7, 13'd1,    1'b1, 1'b0, '0},
      '{REQ_WR_ACQ, 13'd8191, 1'b1, 1'b0, '0},
      '{REQ_WR_REL, 13'd8191, 1'b0, 1'b0, '0},
      '{REQ_RD_ACQ, 13'd0,    1'b0, 1'b0, '0},
      '{REQ_STATUS, 13'd0,    1'b0, 1'b0, '0}
    };
    sizes = '{13'd2, 13'd8191, 13'd0, 13'd1, 13'd3, 13'd37, 13'd4096, 13'd5000,
              13'd0, 13'd300, 13'd4095};
    sizes[8] = FieldW'($urandom_range(2, 8191));

    sz = ResetSize;
    if (sz > MaxSize) sz = MaxSize;
    clear_indices();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    foreach (dir_tbl[i]) begin
      issue(dir_tbl[i].kind, dir_tbl[i].amt, dir_tbl[i].mx, dir_tbl[i].typed,
            dir_tbl[i].res, got);
      maybe_idle();
    end

    foreach (sizes[p]) begin
      load_size(sizes[p]);
      wr_open = 1'b0;
      rd_open = 1'b0;
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        if (p == $size(sizes) - 1) idle_pct = 0;
        else if (i % 40 == 0)
          idle_pct = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(5, 25);
        if (i == 60) drain();
        mx = 1'b0;
        if ($urandom_range(0, 99) < 80) begin
          if ($urandom_range(0, 1) == 0) begin
            if (!wr_open) begin
              kind = REQ_WR_ACQ;
              case ($urandom_range(0, 9))
                0, 1, 2, 3: amt = FieldW'($urandom_range(1, sz / 4 + 1));
                4, 5: begin
                  mx = 1'b1;
                  amt = FieldW'($urandom);
                end
                6, 7: amt = FieldW'($urandom_range(1, sz));
                8: amt = '0;
                default: amt = FieldW'($urandom_range(sz, 8191));
              endcase
            end else begin
              kind = REQ_WR_REL;
              amt = ($urandom_range(0, 9) < 7) ? FieldW'(wr_len)
                                               : FieldW'($urandom_range(0, wr_len));
            end
          end else begin
            if (!rd_open) begin
              kind = REQ_RD_ACQ;
              amt = '0;
            end else begin
              kind = REQ_RD_REL;
              amt = ($urandom_range(0, 9) < 7) ? FieldW'(rd_len)
                                               : FieldW'($urandom_range(0, rd_len));
            end
          end
        end else begin
          // noise: any code, any amount
          kind = ReqTypeW'($urandom_range(0, 7));
          amt = ($urandom_range(0, 1) == 0) ? FieldW'($urandom) : FieldW'($urandom_range(0, sz));
          mx = 1'($urandom_range(0, 1));
        end

        issue(kind, amt, mx, 1'b0, '0, got);
        case (kind)
          REQ_WR_ACQ: begin
            wr_open = got.granted;
            wr_len = got.region_length;
          end
          REQ_WR_REL: wr_open = 1'b0;
          REQ_RD_ACQ: begin
            rd_open = got.granted;
            rd_len = got.region_length;
          end
          REQ_RD_REL: rd_open = 1'b0;
          default: ;
        endcase
        maybe_idle();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bipbuf_pkg.sv
rtl/bipbuf_calc.sv
rtl/bipbuf_state.sv
rtl/bip_buffer_index_manager.sv
sim/testbench.sv
